>>> hw/rtl/pfa_pkg.sv
// ---------------------------------------------------------------------------
// pfa_pkg
// Shared types, codes and defaults for the fixed-partition fit allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

    // defaults for the top-level parameters
    localparam int NUM_BLOCKS_DEF = 8;
    localparam int SIZE_BITS_DEF  = 16;

    // fixed field widths of the stream payloads
    localparam int INDEX_W    = 3;
    localparam int SIZE_W     = 16;
    localparam int POLICY_W   = 2;
    localparam int BCOUNT_W   = 4;
    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int TDATA_W    = 24;

    // placement policy codes
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    // item kind carried in tuser
    localparam logic MODE_DEFINE  = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    localparam logic [BCOUNT_W-1:0] BCOUNT_RST = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/partition_fit_allocator.sv
// ---------------------------------------------------------------------------
// partition_fit_allocator
// Fixed-partition allocator with first, best and worst fit placement.
// ---------------------------------------------------------------------------
// A define item (tuser 0) stores a block size, frees the block and returns
// its echo in the next cycle. A request item (tuser 1) scans the blocks
// one per cycle through a single subtract/compare unit over the size memory,
// whose read data is registered; it scans limit blocks, where limit is
// block_count saturated to NUM_BLOCKS, and first fit ends the scan early
// when it finds a block. The input is not ready during a scan. Each
// item yields exactly one result transaction.
`default_nettype none

module partition_fit_allocator #(
    parameter int NUM_BLOCKS = pfa_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = pfa_pkg::SIZE_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input stream
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [pfa_pkg::TDATA_W-1:0]      i_s_tdata,  // block_index[2:0], size[18:3]
    input  wire logic                             i_s_tuser,  // mode
    // result stream
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic [pfa_pkg::TDATA_W-1:0]           o_m_tdata,  // chosen_block[2:0], fragment[18:3]
    output logic                                  o_m_tuser,  // granted
    // configuration writes
    input  wire logic                             i_cfg_we,
    input  wire logic [pfa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pfa_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int LIM_W = (CNT_W > pfa_pkg::BCOUNT_W) ? CNT_W : pfa_pkg::BCOUNT_W;
    localparam int IXW_W = (IDX_W > pfa_pkg::INDEX_W) ? IDX_W : pfa_pkg::INDEX_W;
    localparam int SZW_W = (SIZE_BITS > pfa_pkg::SIZE_W) ? SIZE_BITS : pfa_pkg::SIZE_W;

    // configuration
    logic [pfa_pkg::POLICY_W-1:0] r_policy;
    logic [pfa_pkg::BCOUNT_W-1:0] r_block_count;

    // block state
    logic [SIZE_BITS-1:0]  mem_size [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_valid;
    logic [NUM_BLOCKS-1:0] r_used;

    // sequencer
    pfa_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]     r_issue;
    logic [CNT_W-1:0]     r_limit;
    logic                 r_pend;
    logic [IDX_W-1:0]     r_pend_idx;
    logic [SIZE_BITS-1:0] r_rd_data;
    logic                 r_rd_ok;
    logic [SIZE_BITS-1:0] r_req;
    logic                 r_found;
    logic [IDX_W-1:0]     r_best_idx;
    logic [SIZE_BITS-1:0] r_best_left;

    // output register
    logic                           r_out_valid;
    logic                           r_out_granted;
    logic [pfa_pkg::INDEX_W-1:0]    r_out_block;
    logic [pfa_pkg::SIZE_W-1:0]     r_out_frag;

    // input unpack
    logic                         w_mode;
    logic [pfa_pkg::INDEX_W-1:0]  w_in_idx;
    logic [pfa_pkg::SIZE_W-1:0]   w_in_size;
    logic [SZW_W-1:0]             w_size_ext;
    logic [SIZE_BITS-1:0]         w_size;
    logic [IXW_W-1:0]             w_idx_ext;
    logic                         w_idx_in_range;

    // limit
    logic [LIM_W-1:0] w_bc_ext;
    logic [LIM_W-1:0] w_limit;

    // shared compare unit
    logic [SIZE_BITS-1:0] w_eff;
    logic [SIZE_BITS-1:0] w_left;
    logic                 w_borrow;
    logic                 w_elig;
    logic                 w_take;
    logic                 w_first_fit;
    logic                 w_more;

    // control
    logic w_accept;
    logic w_out_free;
    logic w_define;
    logic w_start;
    logic w_commit;

    // result formatting
    logic [SZW_W-1:0] w_left_ext;
    logic [IXW_W-1:0] w_best_ext;

    assign w_mode         = i_s_tuser;
    assign w_in_idx       = i_s_tdata[pfa_pkg::INDEX_W-1:0];
    assign w_in_size      = i_s_tdata[pfa_pkg::INDEX_W +: pfa_pkg::SIZE_W];
    assign w_size_ext     = SZW_W'(w_in_size);
    assign w_size         = w_size_ext[SIZE_BITS-1:0];
    assign w_idx_ext      = IXW_W'(w_in_idx);
    assign w_idx_in_range = (32'(w_in_idx) < NUM_BLOCKS);

    assign w_bc_ext = LIM_W'(r_block_count);
    assign w_limit  = (w_bc_ext > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS) : w_bc_ext;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_define   = w_accept && (w_mode == pfa_pkg::MODE_DEFINE);
    assign w_start    = w_accept && (w_mode == pfa_pkg::MODE_REQUEST);

    // never-written entries read as zero
    assign w_eff = r_rd_ok ? r_rd_data : '0;
    assign {w_borrow, w_left} = {1'b0, w_eff} - {1'b0, r_req};

    assign w_first_fit = !(r_policy == pfa_pkg::POL_BEST || r_policy == pfa_pkg::POL_WORST);
    assign w_elig = r_pend && !r_used[r_pend_idx] && !w_borrow;
    assign w_take = w_elig && (!r_found
                    || (r_policy == pfa_pkg::POL_BEST  && w_left < r_best_left)
                    || (r_policy == pfa_pkg::POL_WORST && w_left > r_best_left));
    assign w_more = (r_issue < r_limit);

    assign w_left_ext = SZW_W'(r_best_left);
    assign w_best_ext = IXW_W'(r_best_idx);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfa_pkg::ST_IDLE: begin
                if (w_start) begin
                    n_state = pfa_pkg::ST_SCAN;
                end
            end
            pfa_pkg::ST_SCAN: begin
                if ((w_first_fit && r_found) || (!w_more && !r_pend)) begin
                    n_state = pfa_pkg::ST_DONE;
                end
            end
            pfa_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = pfa_pkg::ST_IDLE;
                end
            end
            default: n_state = pfa_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = 1'b0;
        w_commit   = 1'b0;
        case (r_state)
            pfa_pkg::ST_IDLE: o_s_tready = w_out_free;
            pfa_pkg::ST_SCAN: o_s_tready = 1'b0;
            pfa_pkg::ST_DONE: w_commit   = w_out_free;
            default:          o_s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= pfa_pkg::ST_IDLE;
            r_policy      <= pfa_pkg::POL_FIRST;
            r_block_count <= pfa_pkg::BCOUNT_RST;
            r_valid       <= '0;
            r_used        <= '0;
            r_pend        <= 1'b0;
            r_found       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    pfa_pkg::CFG_POLICY:
                        r_policy <= i_cfg_wdata[pfa_pkg::POLICY_W-1:0];
                    pfa_pkg::CFG_BLOCK_COUNT:
                        r_block_count <= i_cfg_wdata[pfa_pkg::BCOUNT_W-1:0];
                    default: ;
                endcase
            end

            if (w_define && w_idx_in_range) begin
                r_valid[w_idx_ext[IDX_W-1:0]] <= 1'b1;
                r_used[w_idx_ext[IDX_W-1:0]]  <= 1'b0;
            end

            if (w_start) begin
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end else if (r_state == pfa_pkg::ST_SCAN) begin
                r_pend <= w_more;
                if (w_take) begin
                    r_found <= 1'b1;
                end
            end

            if (w_commit && r_found) begin
                r_used[r_best_idx] <= 1'b1;
            end

            if (w_define || w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // size memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_define && w_idx_in_range) begin
            mem_size[w_idx_ext[IDX_W-1:0]] <= w_size;
        end
        r_rd_data <= mem_size[r_issue[IDX_W-1:0]];
        r_rd_ok   <= r_valid[r_issue[IDX_W-1:0]];
    end

    // scan datapath and result payload
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_issue <= '0;
            r_limit <= w_limit[CNT_W-1:0];
            r_req   <= w_size;
        end else if (r_state == pfa_pkg::ST_SCAN && w_more) begin
            r_issue    <= r_issue + 1'b1;
            r_pend_idx <= r_issue[IDX_W-1:0];
        end

        if (r_state == pfa_pkg::ST_SCAN && w_take) begin
            r_best_idx  <= r_pend_idx;
            r_best_left <= w_left;
        end

        if (w_define) begin
            r_out_granted <= 1'b0;
            r_out_block   <= w_in_idx;
            r_out_frag    <= '0;
        end else if (w_commit) begin
            r_out_granted <= r_found;
            r_out_block   <= r_found ? w_best_ext[pfa_pkg::INDEX_W-1:0] : '0;
            r_out_frag    <= r_found ? w_left_ext[pfa_pkg::SIZE_W-1:0] : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_granted;
    assign o_m_tdata  = {{(pfa_pkg::TDATA_W - pfa_pkg::INDEX_W - pfa_pkg::SIZE_W){1'b0}},
                         r_out_frag, r_out_block};

    // a pending read always lies inside the scan window
    a_pend_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfa_pkg::ST_SCAN && r_pend) |-> (CNT_W'(r_pend_idx) < r_limit))
        else $error("pending scan index outside window");

    // a chosen block lies inside the scan window
    a_best_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != pfa_pkg::ST_IDLE && r_found) |-> (CNT_W'(r_best_idx) < r_limit))
        else $error("chosen block outside window");

    // a grant leaves its block marked used
    a_grant_marks_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_found) |=> r_used[$past(r_best_idx)])
        else $error("granted block not marked used");

    // a request never completes in the cycle after it was taken
    a_scan_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == pfa_pkg::ST_SCAN && !r_found))
        else $error("request did not enter scan");

endmodule

`default_nettype wire

>>> test/tb_partition_fit_allocator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_partition_fit_allocator
// Self-checking bench for the fixed-partition fit allocator.
// ---------------------------------------------------------------------------
// A directed table covers the field extremes, every placement policy, ties
// and the odd register settings. Seven random phases follow, each under its
// own policy and block count, with bursty input and a receiver that stalls.
// An in-bench placement model predicts each result the table does not pin,
// and each result is compared field by field in arrival order.

module tb_partition_fit_allocator;

    localparam int NB              = pfa_pkg::NUM_BLOCKS_DEF;
    localparam int INDEX_W         = pfa_pkg::INDEX_W;
    localparam int SIZE_W          = pfa_pkg::SIZE_W;
    localparam int POLICY_W        = pfa_pkg::POLICY_W;
    localparam int BCOUNT_W        = pfa_pkg::BCOUNT_W;
    localparam int CFG_DATA_W      = pfa_pkg::CFG_DATA_W;
    localparam int CFG_IDX_W       = pfa_pkg::CFG_IDX_W;
    localparam int TDATA_W         = pfa_pkg::TDATA_W;
    localparam int LIMIT_CYCLES    = 300000;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 30;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int MAX_REPORTS     = 10;

    // policy code with no meaning of its own; placed like first fit
    localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;

    typedef struct packed {
        logic               granted;
        logic [INDEX_W-1:0] chosen;
        logic [SIZE_W-1:0]  frag;
    } t_grant;

    typedef struct packed {
        logic   pinned;
        t_grant want;
    } t_pin;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  sel;
        logic [CFG_DATA_W-1:0] cval;
        logic                  mode;
        logic [INDEX_W-1:0]    idx;
        logic [SIZE_W-1:0]     sz;
        logic                  pinned;
        t_grant                want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [TDATA_W-1:0]    i_s_tdata;
    logic                  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [TDATA_W-1:0]    o_m_tdata;
    logic                  o_m_tuser;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    partition_fit_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // placement model state
    logic [SIZE_W-1:0]   blk_size [NB];
    logic                blk_used [NB];
    logic [POLICY_W-1:0] cur_pol;
    logic [BCOUNT_W-1:0] cur_cnt;

    t_grant grant_q [$];
    t_pin   pin_q [$];
    t_row   dir_tab [$];

    int   mism_cnt;
    int   cyc_cnt;
    int   burst_left;
    logic hold_req;
    logic hold_done;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt >= LIMIT_CYCLES) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Applies one item to the model and returns the result it produces.
    function automatic t_grant place_item(logic mode, logic [INDEX_W-1:0] idx,
                                          logic [SIZE_W-1:0] sz);
        t_grant            r;
        int                lim;
        int                pick;
        logic              found;
        logic [SIZE_W-1:0] left;
        logic [SIZE_W-1:0] best;
        r     = '0;
        pick  = 0;
        found = 1'b0;
        best  = '0;
        if (mode == pfa_pkg::MODE_DEFINE) begin
            blk_size[idx] = sz;
            blk_used[idx] = 1'b0;
            r.chosen      = idx;
            return r;
        end
        lim = (cur_cnt > NB) ? NB : int'(cur_cnt);
        for (int n = 0; n < lim; n++) begin
            if (!blk_used[n] && blk_size[n] >= sz) begin
                left = blk_size[n] - sz;
                // first fit keeps the first hit; ties keep the lower index
                if (!found) begin
                    found = 1'b1;
                    pick  = n;
                    best  = left;
                end else if (cur_pol == pfa_pkg::POL_BEST && left < best) begin
                    pick = n;
                    best = left;
                end else if (cur_pol == pfa_pkg::POL_WORST && left > best) begin
                    pick = n;
                    best = left;
                end
            end
        end
        if (found) begin
            blk_used[pick] = 1'b1;
            r.granted      = 1'b1;
            r.chosen       = pick[INDEX_W-1:0];
            r.frag         = best;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, t_grant want, t_grant got);
        mism_cnt++;
        if (mism_cnt <= MAX_REPORTS)
            $display({"mismatch (%s): expected granted=%0d block=%0d fragment=%0d,",
                      " got granted=%0d block=%0d fragment=%0d"},
                     what, want.granted, want.chosen, want.frag,
                     got.granted, got.chosen, got.frag);
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_grant got;
        t_grant want;
        t_pin   pin;
        if (i_rst_n !== 1'b1) begin
            for (int b = 0; b < NB; b++) begin
                blk_size[b] = '0;
                blk_used[b] = 1'b0;
            end
            cur_pol = pfa_pkg::POL_FIRST;
            cur_cnt = pfa_pkg::BCOUNT_RST;
        end else begin
            if (o_m_tvalid === 1'b1 && i_m_tready) begin
                got = {o_m_tuser, o_m_tdata[INDEX_W-1:0],
                       o_m_tdata[INDEX_W+SIZE_W-1:INDEX_W]};
                if (grant_q.size() == 0) begin
                    report_mismatch("unexpected", '0, got);
                end else begin
                    want = grant_q.pop_front();
                    if (got.granted !== want.granted || got.chosen !== want.chosen ||
                        got.frag !== want.frag)
                        report_mismatch("field", want, got);
                end
            end
            if (i_s_tvalid && o_s_tready === 1'b1) begin
                want = place_item(i_s_tuser, i_s_tdata[INDEX_W-1:0],
                                  i_s_tdata[INDEX_W+SIZE_W-1:INDEX_W]);
                pin = pin_q.pop_front();
                grant_q.push_back(pin.pinned ? pin.want : want);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pfa_pkg::CFG_POLICY:      cur_pol = i_cfg_wdata[POLICY_W-1:0];
                    pfa_pkg::CFG_BLOCK_COUNT: cur_cnt = i_cfg_wdata[BCOUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Receiver: switches between random stall styles; one long hold-off on request.
    initial begin : receiver
        int style;
        int style_left;
        style      = 0;
        style_left = 0;
        i_m_tready = 1'b0;
        hold_done  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                if (style_left == 0) begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(20, 120);
                end
                style_left--;
                case (style)
                    0: i_m_tready <= 1'b1;
                    1: i_m_tready <= 1'($urandom_range(0, 1));
                    2: i_m_tready <= ($urandom_range(0, 3) == 0);
                    default: i_m_tready <= ~i_m_tready;
                endcase
            end
        end
    end

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Offers one transaction and returns at the edge that accepts it.
    task automatic send_item(logic mode, logic [INDEX_W-1:0] idx, logic [SIZE_W-1:0] sz,
                             logic pinned, t_grant want);
        pin_q.push_back({pinned, want});
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {{(TDATA_W-SIZE_W-INDEX_W){1'b0}}, sz, idx};
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (grant_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pol_val(logic [POLICY_W-1:0] p);
        return {{(CFG_DATA_W-POLICY_W){1'b0}}, p};
    endfunction

    task automatic dir_item(logic mode, logic [INDEX_W-1:0] idx, logic [SIZE_W-1:0] sz,
                            logic pinned, t_grant want);
        dir_tab.push_back('{ROW_ITEM, '0, '0, mode, idx, sz, pinned, want});
    endtask

    task automatic dir_cfg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
        dir_tab.push_back('{ROW_CFG, sel, val, 1'b0, '0, '0, 1'b0, '0});
    endtask

    initial begin : stimulus
        logic                mode;
        logic [INDEX_W-1:0]  idx;
        logic [SIZE_W-1:0]   sz;
        logic [SIZE_W-1:0]   base;
        logic [POLICY_W-1:0] pol;
        logic [BCOUNT_W-1:0] cnt;
        int                  pick;

        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        hold_req    = 1'b0;
        mism_cnt    = 0;
        cyc_cnt     = 0;
        burst_left  = 0;

        // after reset: every block free with size zero, first fit, all 8 blocks
        dir_item(pfa_pkg::MODE_REQUEST, 3'd0, 16'd0,    1'b1, {1'b1, 3'd0, 16'd0});
        dir_item(pfa_pkg::MODE_REQUEST, 3'd5, 16'd1,    1'b1, {1'b0, 3'd0, 16'd0});
        dir_item(pfa_pkg::MODE_DEFINE,  3'd7, 16'hFFFF, 1'b1, {1'b0, 3'd7, 16'd0});
        dir_item(pfa_pkg::MODE_DEFINE,  3'd0, 16'd0,    1'b1, {1'b0, 3'd0, 16'd0});
        dir_item(pfa_pkg::MODE_DEFINE,  3'd1, 16'd100,  1'b1, {1'b0, 3'd1, 16'd0});
        dir_item(pfa_pkg::MODE_DEFINE,  3'd2, 16'd50,   1'b1, {1'b0, 3'd2, 16'd0});
        dir_item(pfa_pkg::MODE_DEFINE,  3'd3, 16'd200,  1'b1, {1'b0, 3'd3, 16'd0});
        dir_item(pfa_pkg::MODE_REQUEST, 3'd0, 16'hFFFF, 1'b1, {1'b1, 3'd7, 16'd0});
        // redefining a used block frees it again
        dir_item(pfa_pkg::MODE_DEFINE,  3'd7, 16'hFFFF, 1'b1, {1'b0, 3'd7, 16'd0});
        dir_cfg(pfa_pkg::CFG_POLICY, pol_val(pfa_pkg::POL_BEST));
        dir_item(pfa_pkg::MODE_REQUEST, 3'd0, 16'd40,   1'b0, '0);
        dir_cfg(pfa_pkg::CFG_POLICY, pol_val(pfa_pkg::POL_WORST));
        dir_item(pfa_pkg::MODE_REQUEST, 3'd6, 16'd40,   1'b0, '0);
        dir_cfg(pfa_pkg::CFG_POLICY, pol_val(POL_SPARE));
        dir_item(pfa_pkg::MODE_REQUEST, 3'd0, 16'd10,   1'b0, '0);
        // no eligible block at all
        dir_cfg(pfa_pkg::CFG_BLOCK_COUNT, 4'd0);
        dir_item(pfa_pkg::MODE_REQUEST, 3'd0, 16'd0,    1'b1, {1'b0, 3'd0, 16'd0});
        // count saturates; equal leftovers go to the lower index
        dir_cfg(pfa_pkg::CFG_BLOCK_COUNT, 4'd15);
        dir_cfg(pfa_pkg::CFG_POLICY, pol_val(pfa_pkg::POL_BEST));
        dir_item(pfa_pkg::MODE_DEFINE,  3'd5, 16'd30,   1'b1, {1'b0, 3'd5, 16'd0});
        dir_item(pfa_pkg::MODE_DEFINE,  3'd6, 16'd30,   1'b1, {1'b0, 3'd6, 16'd0});
        dir_item(pfa_pkg::MODE_REQUEST, 3'd0, 16'd30,   1'b0, '0);
        dir_item(pfa_pkg::MODE_REQUEST, 3'd7, 16'd30,   1'b0, '0);
        dir_cfg(pfa_pkg::CFG_POLICY, pol_val(pfa_pkg::POL_WORST));
        dir_item(pfa_pkg::MODE_DEFINE,  3'd4, 16'd20,   1'b1, {1'b0, 3'd4, 16'd0});
        dir_item(pfa_pkg::MODE_REQUEST, 3'd0, 16'd20,   1'b0, '0);
        dir_item(pfa_pkg::MODE_REQUEST, 3'd0, 16'd0,    1'b0, '0);
        dir_cfg(pfa_pkg::CFG_BLOCK_COUNT, 4'd1);
        dir_item(pfa_pkg::MODE_REQUEST, 3'd3, 16'd0,    1'b0, '0);
        dir_item(pfa_pkg::MODE_REQUEST, 3'd3, 16'd0,    1'b0, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            if (dir_tab[k].kind == ROW_CFG) begin
                drain_results();
                cfg_write(dir_tab[k].sel, dir_tab[k].cval);
            end else begin
                pace();
                send_item(dir_tab[k].mode, dir_tab[k].idx, dir_tab[k].sz,
                          dir_tab[k].pinned, dir_tab[k].want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       begin pol = pfa_pkg::POL_FIRST; cnt = 4'd8;  end
                1:       begin pol = pfa_pkg::POL_BEST;  cnt = 4'd1;  end
                2:       begin pol = pfa_pkg::POL_WORST; cnt = 4'd15; end
                3:       begin pol = POL_SPARE;          cnt = 4'd5;  end
                4:       begin pol = pfa_pkg::POL_BEST;  cnt = 4'd8;  end
                5:       begin pol = pfa_pkg::POL_WORST; cnt = 4'd8;  end
                default: begin
                    pol = POLICY_W'($urandom_range(0, 3));
                    cnt = BCOUNT_W'($urandom_range(0, 15));
                end
            endcase
            drain_results();
            cfg_write(pfa_pkg::CFG_POLICY, pol_val(pol));
            cfg_write(pfa_pkg::CFG_BLOCK_COUNT, cnt);
            // long receiver hold-off while the sender keeps offering
            if (ph == 0) hold_req <= 1'b1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                base = blk_size[$urandom_range(0, NB-1)];
                idx  = INDEX_W'($urandom_range(0, NB-1));
                mode = ($urandom_range(0, 99) < 55) ? pfa_pkg::MODE_REQUEST
                                                    : pfa_pkg::MODE_DEFINE;
                if (mode == pfa_pkg::MODE_REQUEST) begin
                    if (pick < 35)      sz = base;
                    else if (pick < 60) sz = base >> $urandom_range(1, 4);
                    else if (pick < 75) sz = SIZE_W'($urandom_range(0, 255));
                    else if (pick < 92) sz = SIZE_W'($urandom);
                    else if (pick < 96) sz = '0;
                    else                sz = '1;
                end else begin
                    if (pick < 40)      sz = SIZE_W'($urandom_range(0, 255));
                    else if (pick < 75) sz = SIZE_W'($urandom);
                    else if (pick < 82) sz = '1;
                    else if (pick < 88) sz = '0;
                    else                sz = base;    // equal sizes make ties
                end
                pace();
                send_item(mode, idx, sz, 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mism_cnt == 0 && grant_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/pfa_pkg.sv
hw/rtl/partition_fit_allocator.sv
test/tb_partition_fit_allocator.sv
